@@ sv/scg_pkg.sv @@
// Shared types, codes and constants of the stepped clock generator.
package scg_pkg;

	// Field widths
	localparam int ACT_W    = 4;
	localparam int DELTA_W  = 32;
	localparam int FREQ_W   = 27;
	localparam int STAT_W   = 3;
	localparam int ACC_W    = 33;
	localparam int HALF_W   = 33;
	localparam int SUM_W    = 34;
	localparam int EDGES_W  = 2;
	localparam int IN_W     = 64;
	localparam int OUT_W    = 40;

	// Divider geometry: 34-bit dividend, 33-bit divisor, one quotient bit a cycle
	localparam int DVD_W     = 34;
	localparam int DVS_W     = 33;
	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = 6;

	// Frequency limits and band thresholds, in tenths of Hz
	localparam logic [FREQ_W-1:0] MAX_HZ_TENTHS = FREQ_W'(100000000);
	localparam logic [FREQ_W-1:0] MIN_HZ_TENTHS = FREQ_W'(1);
	localparam logic [FREQ_W-1:0] BAND_0 = FREQ_W'(10);
	localparam logic [FREQ_W-1:0] BAND_1 = FREQ_W'(200);
	localparam logic [FREQ_W-1:0] BAND_2 = FREQ_W'(2000);
	localparam logic [FREQ_W-1:0] BAND_3 = FREQ_W'(20000);
	localparam logic [FREQ_W-1:0] STEP_0 = FREQ_W'(1);
	localparam logic [FREQ_W-1:0] STEP_1 = FREQ_W'(10);
	localparam logic [FREQ_W-1:0] STEP_2 = FREQ_W'(100);
	localparam logic [FREQ_W-1:0] STEP_3 = FREQ_W'(1000);
	localparam logic [FREQ_W-1:0] STEP_4 = FREQ_W'(10000);

	// Half-period numerator: 5e9 ns times tenths of Hz
	localparam logic [DVD_W-1:0] NS_HALF_TENTHS = DVD_W'(64'd5000000000);

	// Edges given by one single step
	localparam logic [EDGES_W-1:0] STEP_EDGES = EDGES_W'(2);

	// Request kinds
	typedef enum logic [ACT_W-1:0] {
		ACT_TIME  = 4'd0,
		ACT_START = 4'd1,
		ACT_STOP  = 4'd2,
		ACT_HALT  = 4'd3,
		ACT_STEP  = 4'd4,
		ACT_RESET = 4'd5,
		ACT_SET   = 4'd6,
		ACT_INC   = 4'd7,
		ACT_DEC   = 4'd8
	} action_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_HALTED   = 3'd1,
		ST_RUNNING  = 3'd2,
		ST_UNSET    = 3'd3,
		ST_TOO_LOW  = 3'd4,
		ST_NO_DEC   = 3'd5
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic eval;
		logic div_commit;
		logic load_out;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

@@ sv/scg_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module scg_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [scg_pkg::DVD_W-1:0]  dividend,
	input  logic [scg_pkg::DVS_W-1:0]  divisor,
	output logic                       done,
	output logic [scg_pkg::DVD_W-1:0]  quotient,
	output logic [scg_pkg::DVS_W-1:0]  remainder
);
	import scg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;

	logic [DVS_W:0]       trial;
	logic [DVS_W:0]       diff;
	logic                 ge;
	logic                 last;

	// Trial subtraction for the next quotient bit
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign last  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// Control: busy until the last of DIV_STEPS quotient steps, done pulse after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: dividend shifts out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

@@ sv/scg_datapath.sv @@
// Datapath: clock state, request evaluation, divider and output register.
module scg_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  scg_pkg::cmd_t              cmd,
	output scg_pkg::sts_t              sts,
	input  logic [scg_pkg::ACT_W-1:0]  in_action,
	input  logic [scg_pkg::IN_W-1:0]   in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [scg_pkg::OUT_W-1:0]  out_data
);
	import scg_pkg::*;

	// Captured request
	logic [ACT_W-1:0]   action_q;
	logic [DELTA_W-1:0] delta_q;
	logic [FREQ_W-1:0]  req_q;

	// Clock state
	logic [ACC_W-1:0]   accum_q;
	logic [HALF_W-1:0]  half_q;
	logic [FREQ_W-1:0]  freq_q;
	logic               run_q;
	logic               halt_q;
	logic               rising_q;
	logic               stepping_q;
	logic [EDGES_W-1:0] edges_q;
	logic               div_freq_q;

	// Result fields held until the output register loads
	logic               res_edge_q;
	logic               res_rising_q;
	status_t            res_status_q;
	logic               res_changed_q;

	// Output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	// Evaluation results
	logic [ACC_W-1:0]   nxt_accum;
	logic               nxt_run;
	logic               nxt_halt;
	logic               nxt_rising;
	logic               nxt_stepping;
	logic [EDGES_W-1:0] nxt_edges;
	logic [FREQ_W-1:0]  nxt_freq;
	logic               ev_edge;
	logic               ev_rising;
	status_t            ev_status;
	logic               ev_changed;
	logic               ev_div_freq;
	logic               need_div;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;

	logic [SUM_W-1:0]   sum;
	logic [EDGES_W-1:0] edges_dec;
	logic [FREQ_W-1:0]  f_inc;
	logic [FREQ_W-1:0]  f_dec;
	logic [FREQ_W-1:0]  f_raw;
	logic [FREQ_W-1:0]  f_clamp;
	logic               half_set;

	logic               div_done;
	logic [DVD_W-1:0]   div_quo;
	logic [DVS_W-1:0]   div_rem;

	// Accumulated time and step edge count
	assign sum       = {1'b0, accum_q} + SUM_W'(delta_q);
	assign edges_dec = (edges_q != '0) ? edges_q - EDGES_W'(1) : edges_q;
	assign half_set  = (half_q != '0);

	// Band step up and down
	always_comb begin
		if (freq_q < BAND_0) begin
			f_inc = freq_q + STEP_0;
		end else if (freq_q < BAND_1) begin
			f_inc = freq_q + STEP_1;
		end else if (freq_q < BAND_2) begin
			f_inc = freq_q + STEP_2;
		end else if (freq_q < BAND_3) begin
			f_inc = freq_q + STEP_3;
		end else begin
			f_inc = freq_q + STEP_4;
		end
	end

	always_comb begin
		if (freq_q <= BAND_0) begin
			f_dec = freq_q - STEP_0;
		end else if (freq_q <= BAND_1) begin
			f_dec = freq_q - STEP_1;
		end else if (freq_q <= BAND_2) begin
			f_dec = freq_q - STEP_2;
		end else if (freq_q <= BAND_3) begin
			f_dec = freq_q - STEP_3;
		end else begin
			f_dec = freq_q - STEP_4;
		end
	end

	// Source of a new frequency, then clamp to floor and ceiling
	always_comb begin
		case (action_q)
			ACT_SET: f_raw = req_q;
			ACT_INC: f_raw = f_inc;
			default: f_raw = f_dec;
		endcase
		if (f_raw > MAX_HZ_TENTHS) begin
			f_clamp = MAX_HZ_TENTHS;
		end else if (f_raw == '0) begin
			f_clamp = MIN_HZ_TENTHS;
		end else begin
			f_clamp = f_raw;
		end
	end

	// Request evaluation
	always_comb begin
		nxt_accum    = accum_q;
		nxt_run      = run_q;
		nxt_halt     = halt_q;
		nxt_rising   = rising_q;
		nxt_stepping = stepping_q;
		nxt_edges    = edges_q;
		nxt_freq     = freq_q;
		ev_edge      = 1'b0;
		ev_rising    = 1'b0;
		ev_status    = ST_OK;
		ev_changed   = 1'b0;
		ev_div_freq  = 1'b0;
		need_div     = 1'b0;
		div_dvd      = NS_HALF_TENTHS;
		div_dvs      = DVS_W'(f_clamp);
		case (action_q)
			ACT_TIME: begin
				if (run_q && half_set) begin
					if (sum >= SUM_W'(half_q)) begin
						// edge due: remainder comes from the divider
						need_div   = 1'b1;
						div_dvd    = sum;
						div_dvs    = half_q;
						ev_edge    = 1'b1;
						ev_rising  = rising_q;
						nxt_rising = !rising_q;
						if (stepping_q) begin
							nxt_edges = edges_dec;
							if (edges_dec == '0) begin
								nxt_run      = 1'b0;
								nxt_stepping = 1'b0;
							end
						end
					end else begin
						nxt_accum = sum[ACC_W-1:0];
					end
				end
			end
			ACT_START: begin
				if (halt_q) begin
					ev_status = ST_HALTED;
				end else if (!half_set) begin
					ev_status = ST_UNSET;
				end else begin
					nxt_accum    = '0;
					nxt_run      = 1'b1;
					nxt_rising   = 1'b1;
					nxt_stepping = 1'b0;
					nxt_edges    = '0;
				end
			end
			ACT_STOP: begin
				nxt_run      = 1'b0;
				nxt_stepping = 1'b0;
				nxt_edges    = '0;
			end
			ACT_HALT: begin
				nxt_halt     = 1'b1;
				nxt_run      = 1'b0;
				nxt_stepping = 1'b0;
				nxt_edges    = '0;
			end
			ACT_STEP: begin
				if (halt_q) begin
					ev_status = ST_HALTED;
				end else if (run_q) begin
					ev_status = ST_RUNNING;
				end else if (!half_set) begin
					ev_status = ST_UNSET;
				end else begin
					nxt_accum    = '0;
					nxt_run      = 1'b1;
					nxt_rising   = 1'b1;
					nxt_stepping = 1'b1;
					nxt_edges    = STEP_EDGES;
				end
			end
			ACT_RESET: begin
				nxt_halt = 1'b0;
			end
			ACT_SET: begin
				if (req_q == '0) begin
					ev_status = ST_TOO_LOW;
				end else begin
					nxt_freq    = f_clamp;
					ev_changed  = 1'b1;
					ev_div_freq = 1'b1;
					need_div    = 1'b1;
				end
			end
			ACT_INC: begin
				nxt_freq    = f_clamp;
				ev_changed  = 1'b1;
				ev_div_freq = 1'b1;
				need_div    = 1'b1;
			end
			ACT_DEC: begin
				if (freq_q <= MIN_HZ_TENTHS) begin
					ev_status = ST_NO_DEC;
				end else begin
					nxt_freq    = f_clamp;
					ev_changed  = 1'b1;
					ev_div_freq = 1'b1;
					need_div    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Shared divider: half period or accumulator remainder
	scg_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.eval && need_div),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			delta_q  <= in_data[DELTA_W-1:0];
			req_q    <= in_data[DELTA_W+FREQ_W-1:DELTA_W];
		end
	end

	// Clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q    <= '0;
			half_q     <= '0;
			freq_q     <= '0;
			run_q      <= 1'b0;
			halt_q     <= 1'b0;
			rising_q   <= 1'b0;
			stepping_q <= 1'b0;
			edges_q    <= '0;
			div_freq_q <= 1'b0;
		end else if (cmd.eval) begin
			accum_q    <= nxt_accum;
			freq_q     <= nxt_freq;
			run_q      <= nxt_run;
			halt_q     <= nxt_halt;
			rising_q   <= nxt_rising;
			stepping_q <= nxt_stepping;
			edges_q    <= nxt_edges;
			div_freq_q <= ev_div_freq;
		end else if (cmd.div_commit) begin
			if (div_freq_q) begin
				half_q <= div_quo[HALF_W-1:0];
			end else begin
				accum_q <= div_rem;
			end
		end
	end

	// Result fields
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			res_edge_q    <= ev_edge;
			res_rising_q  <= ev_rising;
			res_status_q  <= ev_status;
			res_changed_q <= ev_changed;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {{(OUT_W - FREQ_W - STAT_W - 4){1'b0}}, freq_q, res_changed_q,
				run_q, res_status_q, res_rising_q, res_edge_q};
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign sts.need_div = need_div;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

@@ sv/scg_ctrl.sv @@
// Controller: sequences capture, evaluation, division and result load.
module scg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  scg_pkg::sts_t sts,
	output scg_pkg::cmd_t cmd
);
	import scg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		in_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.need_div ? S_DIV : S_DONE;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.div_commit = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/stepped_clock_generator_core.sv @@
// A request passes capture, evaluation, a division when one runs, and the result load.
// Frequency changes and time requests that produce an edge run the 34-step radix-2
// divider; the result load waits until the output register is free.
// One request is worked on at a time; the output register frees the input side.
// Reset (arst_n low, asynchronous): clock stopped, not halted, frequency and
// half period zero (unset), accumulator zero, no result pending.
module stepped_clock_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] delta_ns, [58:32] new_hz_tenths, [63:59] zero
	input  logic [63:0] s_tdata,
	// [3:0] action
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] edge_valid, [1] edge_rising, [4:2] status, [5] is_running,
	// [6] freq_changed, [33:7] current_hz_tenths, [39:34] zero
	output logic [39:0] m_tdata
);
	import scg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	scg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_action (s_tuser),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef SYNTHESIS
	// One request at a time: no request taken straight after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one in progress");

	// Divider finishes only while a request is in progress (input not ready)
	a_div_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> !s_tready)
		else $error("divider completion outside a division");

	// A rising edge is always a produced edge
	a_rising_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
		else $error("rising flag without an edge");

	// Reported frequency stays within the ceiling
	a_freq_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[33:7] <= MAX_HZ_TENTHS))
		else $error("frequency above ceiling");
`endif

endmodule
